// ===== src/assert_macros.svh =====
// Assertion helpers included by the dedup filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is quiet while reset is held.
`define PVDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define PVDF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== src/pvdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Polyline vertex dedup filter package
// Table depth, derived widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package pvdf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ID_W         = 64;
    localparam int COORD_W      = 64;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Number of 8:1 OR passes that fold the match vector down to one bit.
    function automatic int clog8(input int n);
        int steps;
        int rem;
        steps = 0;
        rem   = n;
        while (rem > 1) begin
            rem   = (rem + 7) / 8;
            steps = steps + 1;
        end
        return steps;
    endfunction

    localparam int RED_STEPS = clog8(MAX_VERTICES);
    localparam int STEP_W    = $clog2(RED_STEPS + 1);

    typedef struct packed {
        logic shift_id;
        logic shift_coord;
        logic id_valid;
        logic coord_valid;
    } cell_ctrl_t;

endpackage

// ===== src/pvdf_cell.sv =====
// ----------------------------------------------------------------------------
// Dedup table cell
// Holds one stored id and one stored coordinate, compares both with the
// current vertex and passes its entries to the next cell on a shift.
// ----------------------------------------------------------------------------
module pvdf_cell
    import pvdf_pkg::*;
(
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic [ID_W-1:0]    id_in,
    input  logic [COORD_W-1:0] coord_in,
    input  logic [ID_W-1:0]    key_id,
    input  logic [COORD_W-1:0] key_coord,
    output logic [ID_W-1:0]    id_out,
    output logic [COORD_W-1:0] coord_out,
    output logic               id_match,
    output logic               coord_match
);

    logic [ID_W-1:0]    id_reg;
    logic [COORD_W-1:0] coord_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift_id) begin
            id_reg <= id_in;
        end
        if (ctrl.shift_coord) begin
            coord_reg <= coord_in;
        end
    end

    assign id_out      = id_reg;
    assign coord_out   = coord_reg;
    assign id_match    = ctrl.id_valid && (id_reg == key_id);
    assign coord_match = ctrl.coord_valid && (coord_reg == key_coord);

endmodule

// ===== src/polyline_vertex_dedup_filter.sv =====
// ----------------------------------------------------------------------------
// Polyline vertex dedup filter
// Drops vertices whose node id or coordinate repeats an earlier vertex of the
// same line, with ring closing and zero-length line detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one vertex each: node id, x and y in tdata and the
//   last-vertex mark in s_tlast. Each input beat yields exactly one output
//   beat whose tdata holds the keep and status flags; m_tlast echoes the
//   last-vertex mark.
//   The stored ids and coordinates sit in a row of cells that all compare
//   against the vertex at once; new entries enter at cell 0 and the row
//   shifts by one. The per-cell match bits are folded by a registered 8:1
//   OR pass per cycle; the result is then committed to the output register,
//   m_tvalid rises, and only then does the filter return to idle and accept
//   the next vertex, so a new vertex is not taken while the last is in flight.
//   The output register holds a finished result while the receiver stalls;
//   the next vertex is still accepted and compared, and its result waits
//   until the output register frees.
//   Reset empties both tables and the line state at once; no clearing pass.
// ----------------------------------------------------------------------------
module polyline_vertex_dedup_filter
    import pvdf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // node_id[63:0], coord_x[95:64], coord_y[127:96]
    input  logic         s_tlast,  // last_vertex
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,  // keep, id_repeat, coord_repeat,
                                   // zero_length_line, table_overflow, zero pad
    output logic         m_tlast   // end_of_line
);

`include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_COM  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [ID_W-1:0]       key_id_reg;
    logic [COORD_W-1:0]    key_coord_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      id_cnt_reg, id_cnt_next;
    logic [CNT_W-1:0]      coord_cnt_reg, coord_cnt_next;
    logic [ID_W-1:0]       first_id_reg, first_id_next;
    logic [COORD_W-1:0]    first_coord_reg;
    logic [1:0]            pos_reg, pos_next;
    logic [MAX_VERTICES-1:0] id_red_reg, id_red_next;
    logic [MAX_VERTICES-1:0] coord_red_reg, coord_red_next;
    logic                  m_tvalid_reg;
    logic [4:0]            m_flags_reg;
    logic                  m_tlast_reg;

    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic                  id_hit, coord_hit, ring_close, pair_dup;
    logic                  store_id, store_coord, overflow;
    logic                  keep, id_rep, coord_rep, zero_len;

    cell_ctrl_t                       ctrl   [MAX_VERTICES];
    logic [ID_W-1:0]                  id_q   [MAX_VERTICES];
    logic [COORD_W-1:0]               coord_q[MAX_VERTICES];
    logic [MAX_VERTICES-1:0]          id_match, coord_match;

    function automatic logic [MAX_VERTICES-1:0] fold8(input logic [MAX_VERTICES-1:0] v);
        logic [MAX_VERTICES-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (v[i]) begin
                r[i / 8] = 1'b1;
            end
        end
        return r;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_COM) && out_free;

    // Decision for the vertex under test, used in the commit cycle.
    always_comb begin
        id_hit      = id_red_reg[0];
        coord_hit   = coord_red_reg[0];
        ring_close  = last_reg && (pos_reg != 2'd0) && (key_id_reg == first_id_reg);
        pair_dup    = (key_id_reg == first_id_reg) || (key_coord_reg == first_coord_reg);
        id_rep      = id_hit && !ring_close;
        coord_rep   = coord_hit && !ring_close;
        keep        = !(id_rep || coord_rep);
        zero_len    = last_reg && (pos_reg == 2'd1) && pair_dup;
        store_id    = !id_hit && (id_cnt_reg < CNT_W'(MAX_VERTICES));
        store_coord = !coord_hit && (coord_cnt_reg < CNT_W'(MAX_VERTICES));
        overflow    = (!id_hit && !store_id) || (!coord_hit && !store_coord);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
            logic [ID_W-1:0]    id_src;
            logic [COORD_W-1:0] coord_src;

            if (g == 0) begin : g_head
                assign id_src    = key_id_reg;
                assign coord_src = key_coord_reg;
            end else begin : g_body
                assign id_src    = id_q[g-1];
                assign coord_src = coord_q[g-1];
            end

            assign ctrl[g].shift_id    = commit && store_id;
            assign ctrl[g].shift_coord = commit && store_coord;
            assign ctrl[g].id_valid    = CNT_W'(g) < id_cnt_reg;
            assign ctrl[g].coord_valid = CNT_W'(g) < coord_cnt_reg;

            pvdf_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl[g]),
                .id_in       (id_src),
                .coord_in    (coord_src),
                .key_id      (key_id_reg),
                .key_coord   (key_coord_reg),
                .id_out      (id_q[g]),
                .coord_out   (coord_q[g]),
                .id_match    (id_match[g]),
                .coord_match (coord_match[g])
            );
        end
    endgenerate

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        id_red_next    = id_red_reg;
        coord_red_next = coord_red_reg;
        id_cnt_next    = id_cnt_reg;
        coord_cnt_next = coord_cnt_reg;
        first_id_next  = first_id_reg;
        pos_next       = pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                id_red_next    = id_match;
                coord_red_next = coord_match;
                step_next      = '0;
                state_next     = ST_RED;
            end
            ST_RED: begin
                id_red_next    = fold8(id_red_reg);
                coord_red_next = fold8(coord_red_reg);
                step_next      = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(RED_STEPS - 1)) begin
                    state_next = ST_COM;
                end
            end
            ST_COM: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (store_id) begin
                        id_cnt_next = id_cnt_reg + CNT_W'(1);
                    end
                    if (store_coord) begin
                        coord_cnt_next = coord_cnt_reg + CNT_W'(1);
                    end
                    if (pos_reg == 2'd0) begin
                        first_id_next = key_id_reg;
                    end
                    if (pos_reg != 2'd3) begin
                        pos_next = pos_reg + 2'd1;
                    end
                    if (last_reg) begin
                        id_cnt_next    = '0;
                        coord_cnt_next = '0;
                        first_id_next  = '0;
                        pos_next       = 2'd0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            id_cnt_reg    <= '0;
            coord_cnt_reg <= '0;
            first_id_reg  <= '0;
            pos_reg       <= 2'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            id_cnt_reg    <= id_cnt_next;
            coord_cnt_reg <= coord_cnt_next;
            first_id_reg  <= first_id_next;
            pos_reg       <= pos_next;
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        step_reg      <= step_next;
        id_red_reg    <= id_red_next;
        coord_red_reg <= coord_red_next;
        if (accept) begin
            key_id_reg    <= s_tdata[63:0];
            key_coord_reg <= {s_tdata[95:64], s_tdata[127:96]};
            last_reg      <= s_tlast;
        end
        // The first coordinate stands in for table entry zero on the second vertex.
        if (commit && (pos_reg == 2'd0)) begin
            first_coord_reg <= key_coord_reg;
        end
        if (commit) begin
            m_flags_reg <= {overflow, zero_len, coord_rep, id_rep, keep};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_flags_reg};
    assign m_tlast  = m_tlast_reg;

    `PVDF_ASSERT(a_cnt_bound, (id_cnt_reg <= CNT_W'(MAX_VERTICES)) && (coord_cnt_reg <= CNT_W'(MAX_VERTICES)), "table count beyond table depth")
    `PVDF_ASSERT(a_line_clear, commit && last_reg |=> (id_cnt_reg == '0) && (coord_cnt_reg == '0) && (pos_reg == 2'd0), "line state not cleared after last vertex")
    `PVDF_ASSERT(a_ring_keep, commit && ring_close |=> m_tvalid && m_tdata[0], "ring-closing vertex was dropped")
    `PVDF_ASSERT(a_busy_no_accept, (state_reg != ST_IDLE) |-> !s_tready, "input accepted while a vertex is in flight")

endmodule
